[sv/ppi_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the plane-plane intersection block.
// No dependencies.
package ppi_pkg;

  localparam int unsigned NormalFracBits = 14;
  localparam int unsigned NrmW     = 16;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned TolW     = 15;
  localparam int unsigned TolSqW   = 2 * TolW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // cross product path
  localparam int unsigned PrdW   = 2 * NrmW;
  localparam int unsigned DiffW  = PrdW + 1;
  localparam int unsigned CrossW = DiffW - NormalFracBits;
  localparam int unsigned CMagW  = CrossW - 1;
  localparam int unsigned SumW   = 2 * CMagW;

  // point path
  localparam int unsigned UvW   = NrmW + CrossW;
  localparam int unsigned KW    = CoordW + 1;
  localparam int unsigned KuW   = KW + UvW;
  localparam int unsigned NW    = KuW + 1;
  localparam int unsigned PNumW = NW + 1;
  localparam int unsigned PQW   = CoordW + 1;

  // direction path
  localparam int unsigned LenShift = 16;
  localparam int unsigned SqInW    = SumW + LenShift;
  localparam int unsigned LenW     = SqInW / 2;
  localparam int unsigned DirShift = NormalFracBits + 8;
  localparam int unsigned DirNumW  = CMagW + DirShift + 1;
  localparam int unsigned DirQW    = NrmW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNormalX,
    CfgNormalY,
    CfgNormalZ,
    CfgOffset,
    CfgTol
  } cfg_idx_e;

  typedef struct packed {
    logic                     intersects;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [NrmW-1:0]   dir_x;
    logic signed [NrmW-1:0]   dir_y;
    logic signed [NrmW-1:0]   dir_z;
  } res_t;

endpackage

[sv/ppi_delay.sv]
`timescale 1ns / 1ps
// Enabled shift-register delay line for pipeline side data.
// No dependencies.
module ppi_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

[sv/ppi_div.sv]
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Flags quotients of 2^Q_W or more. No dependencies.
module ppi_div #(
  parameter int unsigned NUM_W = 70,
  parameter int unsigned DEN_W = 36,
  parameter int unsigned Q_W   = 33
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             ovf_o
);

  localparam int unsigned HiW  = NUM_W - Q_W;
  localparam int unsigned CmpW = (HiW > DEN_W) ? HiW : DEN_W;

  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [DEN_W-1:0] rem_d [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [DEN_W-1:0] den_d [Q_W+1];
  logic [Q_W-1:0]   lo_q  [Q_W+1];
  logic [Q_W-1:0]   lo_d  [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic [Q_W-1:0]   quo_d [Q_W+1];
  logic             ovf_q [Q_W+1];
  logic             ovf_d [Q_W+1];

  always_comb begin
    logic [DEN_W:0] t;
    logic           ge;
    rem_d[0] = DEN_W'(num_i[NUM_W-1:Q_W]);
    den_d[0] = den_i;
    lo_d[0]  = num_i[Q_W-1:0];
    quo_d[0] = '0;
    ovf_d[0] = CmpW'(num_i[NUM_W-1:Q_W]) >= CmpW'(den_i);
    for (int k = 0; k < Q_W; k++) begin
      t            = {rem_q[k], lo_q[k][Q_W-1-k]};
      ge           = t >= {1'b0, den_q[k]};
      rem_d[k+1]   = ge ? DEN_W'(t - {1'b0, den_q[k]}) : t[DEN_W-1:0];
      quo_d[k+1]   = {quo_q[k][Q_W-2:0], ge};
      den_d[k+1]   = den_q[k];
      lo_d[k+1]    = lo_q[k];
      ovf_d[k+1]   = ovf_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      lo_q  <= lo_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  assign quo_o = quo_q[Q_W];
  assign ovf_o = ovf_q[Q_W];

endmodule

[sv/ppi_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root (floor), one root bit per stage.
// No dependencies.
module ppi_sqrt #(
  parameter int unsigned IN_W = 52
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   v_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int unsigned OutW = IN_W / 2;
  localparam int unsigned RemW = OutW + 2;

  logic [IN_W-1:0] v_q    [OutW+1];
  logic [IN_W-1:0] v_d    [OutW+1];
  logic [RemW-1:0] rem_q  [OutW+1];
  logic [RemW-1:0] rem_d  [OutW+1];
  logic [OutW-1:0] root_q [OutW+1];
  logic [OutW-1:0] root_d [OutW+1];

  always_comb begin
    logic [RemW+1:0] t;
    logic [RemW+1:0] trial;
    logic            ge;
    v_d[0]    = v_i;
    rem_d[0]  = '0;
    root_d[0] = '0;
    for (int k = 0; k < OutW; k++) begin
      t           = {rem_q[k], v_q[k][IN_W-1-2*k -: 2]};
      trial       = {2'b00, root_q[k], 2'b01};
      ge          = t >= trial;
      rem_d[k+1]  = ge ? RemW'(t - trial) : RemW'(t);
      root_d[k+1] = {root_q[k][OutW-2:0], ge};
      v_d[k+1]    = v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q    <= v_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q[OutW];

endmodule

[sv/plane_plane_intersection.sv]
`timescale 1ns / 1ps
// Plane-plane intersection top level: cross product front end, point and
// direction pipelines, output FIFO. Uses ppi_pkg, ppi_delay, ppi_div, ppi_sqrt.
//
// Usage:
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   loads the reference normal, offset and parallel tolerance; it is always
//   ready. The user must write it only while no request is in flight; the
//   block itself does not enforce this. Unknown indexes are ignored.
//   Input channel (in_valid_i/in_ready_o) takes one plane per request; the
//   output channel (out_valid_o/out_ready_i) returns one result per request,
//   in order.
//   Throughput: one request per cycle while in_ready_o is high. A request
//   passes through the 50-stage pipeline (cross product, 33-step point
//   divider, 26-step square root and 16-step direction divider) and then
//   the output FIFO before its result is offered.
//   Reset clears all valid bits, empties the FIFO and loads the reference
//   plane z = 0 with tolerance 16.
//   When the receiver stalls, results collect in a two-entry FIFO; once it
//   holds two, the whole pipeline freezes and in_ready_o drops, so nothing
//   is lost or repeated.
module plane_plane_intersection (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [ppi_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic        [ppi_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [ppi_pkg::NrmW-1:0]      other_normal_x_i,
  input  logic signed [ppi_pkg::NrmW-1:0]      other_normal_y_i,
  input  logic signed [ppi_pkg::NrmW-1:0]      other_normal_z_i,
  input  logic signed [ppi_pkg::CoordW-1:0]    other_offset_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 intersects_o,
  output logic signed [ppi_pkg::CoordW-1:0]    point_x_o,
  output logic signed [ppi_pkg::CoordW-1:0]    point_y_o,
  output logic signed [ppi_pkg::CoordW-1:0]    point_z_o,
  output logic signed [ppi_pkg::NrmW-1:0]      dir_x_o,
  output logic signed [ppi_pkg::NrmW-1:0]      dir_y_o,
  output logic signed [ppi_pkg::NrmW-1:0]      dir_z_o
);

  import ppi_pkg::*;

  localparam int unsigned PtDivLat  = PQW + 1;
  localparam int unsigned DirDivLat = DirQW + 1;
  localparam int unsigned SqrtLat   = LenW + 1;
  localparam int unsigned PtLat     = 3 + PtDivLat + 1;
  localparam int unsigned DirLat    = SqrtLat + 1 + DirDivLat + 1;
  localparam int unsigned PadDepth  = DirLat - PtLat;
  localparam int unsigned PipeDepth = 4 + DirLat;
  localparam int unsigned J [3] = '{1, 2, 0};
  localparam int unsigned K [3] = '{2, 0, 1};

  localparam logic [PQW-1:0]    PtPosLim  = PQW'({(CoordW-1){1'b1}});
  localparam logic [PQW-1:0]    PtNegLim  = PQW'(1) << (CoordW - 1);
  localparam logic [CoordW-1:0] PtPosSat  = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] PtNegSat  = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [DirQW-1:0]  DirPosLim = {1'b0, {(DirQW-1){1'b1}}};
  localparam logic [DirQW-1:0]  DirNegLim = {1'b1, {(DirQW-1){1'b0}}};

  // configuration
  logic signed [NrmW-1:0]   ref_n_q [3];
  logic signed [CoordW-1:0] ref_off_q;
  logic        [TolW-1:0]   tol_q;
  logic signed [KW-1:0]     k1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_n_q[0] <= '0;
      ref_n_q[1] <= '0;
      ref_n_q[2] <= NrmW'(1 << NormalFracBits);
      ref_off_q  <= '0;
      tol_q      <= TolW'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgNormalX: ref_n_q[0] <= cfg_data_i[NrmW-1:0];
        CfgNormalY: ref_n_q[1] <= cfg_data_i[NrmW-1:0];
        CfgNormalZ: ref_n_q[2] <= cfg_data_i[NrmW-1:0];
        CfgOffset:  ref_off_q  <= cfg_data_i[CoordW-1:0];
        CfgTol:     tol_q      <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  assign k1 = -KW'(ref_off_q);

  // flow control
  logic                 en;
  logic                 push;
  logic                 pop;
  logic [PipeDepth-1:0] vld_q;
  logic [1:0]           cnt_q;
  logic                 wptr_q;
  logic                 rptr_q;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;
  assign push       = en && vld_q[PipeDepth-1];
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  // front end stages
  logic signed [NrmW-1:0]   in_b [3];
  logic signed [PrdW-1:0]   s1_pa_q [3], s1_pa_d [3], s1_pb_q [3], s1_pb_d [3];
  logic signed [NrmW-1:0]   s1_b_q [3];
  logic signed [KW-1:0]     s1_k2_q, s1_k2_d;
  logic signed [CrossW-1:0] s2_c_q [3], s2_c_d [3];
  logic signed [NrmW-1:0]   s2_b_q [3];
  logic signed [KW-1:0]     s2_k2_q;
  logic        [SumW-1:0]   s3_sq_q [3], s3_sq_d [3];
  logic signed [UvW-1:0]    s3_ua_q [3], s3_ua_d [3], s3_ub_q [3], s3_ub_d [3];
  logic signed [UvW-1:0]    s3_va_q [3], s3_va_d [3], s3_vb_q [3], s3_vb_d [3];
  logic        [TolSqW-1:0] s3_tol2_q, s3_tol2_d;
  logic signed [CrossW-1:0] s3_c_q [3];
  logic signed [KW-1:0]     s3_k2_q;
  logic        [SumW-1:0]   s4_s_q, s4_s_d;
  logic                     s4_par_q, s4_par_d;
  logic signed [UvW-1:0]    s4_u_q [3], s4_u_d [3], s4_v_q [3], s4_v_d [3];
  logic signed [CrossW-1:0] s4_c_q [3];
  logic signed [KW-1:0]     s4_k2_q;

  assign in_b[0] = other_normal_x_i;
  assign in_b[1] = other_normal_y_i;
  assign in_b[2] = other_normal_z_i;

  always_comb begin
    logic signed [DiffW-1:0]  d;
    logic        [DiffW-1:0]  mag;
    logic        [DiffW-1:0]  rnd;
    logic        [CMagW-1:0]  cm;
    for (int i = 0; i < 3; i++) begin
      s1_pa_d[i] = ref_n_q[J[i]] * in_b[K[i]];
      s1_pb_d[i] = ref_n_q[K[i]] * in_b[J[i]];

      d   = DiffW'(s1_pa_q[i]) - DiffW'(s1_pb_q[i]);
      mag = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
      rnd = (mag + (DiffW'(1) << (NormalFracBits - 1))) >> NormalFracBits;
      s2_c_d[i] = d[DiffW-1] ? -$signed(CrossW'(rnd)) : $signed(CrossW'(rnd));

      cm = s2_c_q[i][CrossW-1] ? CMagW'(-s2_c_q[i]) : CMagW'(s2_c_q[i]);
      s3_sq_d[i] = SumW'(cm) * SumW'(cm);
      s3_ua_d[i] = s2_b_q[J[i]] * s2_c_q[K[i]];
      s3_ub_d[i] = s2_b_q[K[i]] * s2_c_q[J[i]];
      s3_va_d[i] = s2_c_q[J[i]] * ref_n_q[K[i]];
      s3_vb_d[i] = s2_c_q[K[i]] * ref_n_q[J[i]];

      s4_u_d[i] = UvW'(s3_ua_q[i] - s3_ub_q[i]);
      s4_v_d[i] = UvW'(s3_va_q[i] - s3_vb_q[i]);
    end
    s1_k2_d   = -KW'(other_offset_i);
    s3_tol2_d = TolSqW'(tol_q) * TolSqW'(tol_q);
    s4_s_d    = s3_sq_q[0] + s3_sq_q[1] + s3_sq_q[2];
    s4_par_d  = s4_s_d <= SumW'(s3_tol2_q);
  end

  // point path
  logic signed [KuW-1:0]   s5_ku_q [3], s5_ku_d [3], s5_kv_q [3], s5_kv_d [3];
  logic        [SumW-1:0]  s5_s_q;
  logic signed [NW-1:0]    s6_n_q [3], s6_n_d [3];
  logic        [SumW-1:0]  s6_s_q;
  logic        [PNumW-1:0] s7_num_q [3], s7_num_d [3];
  logic                    s7_neg_q [3], s7_neg_d [3];
  logic        [SumW-1:0]  s7_s_q;
  logic        [PQW-1:0]   pquo [3];
  logic                    povf [3];
  logic                    pneg_dl [3];
  logic        [CoordW-1:0] pt_q [3], pt_d [3];
  logic        [CoordW-1:0] pt_dl [3];

  always_comb begin
    logic [NW-1:0] nmag;
    for (int i = 0; i < 3; i++) begin
      s5_ku_d[i] = k1 * s4_u_q[i];
      s5_kv_d[i] = s4_k2_q * s4_v_q[i];
      s6_n_d[i]  = NW'(s5_ku_q[i]) + NW'(s5_kv_q[i]);
      s7_neg_d[i] = s6_n_q[i][NW-1];
      nmag = s6_n_q[i][NW-1] ? NW'(-s6_n_q[i]) : NW'(s6_n_q[i]);
      s7_num_d[i] = PNumW'(nmag) + PNumW'(s6_s_q >> 1);
      if (pneg_dl[i]) begin
        pt_d[i] = (povf[i] || pquo[i] > PtNegLim) ? PtNegSat : CoordW'(-pquo[i]);
      end else begin
        pt_d[i] = (povf[i] || pquo[i] > PtPosLim) ? PtPosSat : CoordW'(pquo[i]);
      end
    end
  end

  // direction path
  logic        [LenW-1:0]    len;
  logic signed [CrossW-1:0]  c_dl [3];
  logic        [DirNumW-1:0] dn_num_q [3], dn_num_d [3];
  logic                      dn_neg_q [3], dn_neg_d [3];
  logic        [LenW-1:0]    dn_len_q;
  logic        [DirQW-1:0]   dquo [3];
  logic                      dovf [3];
  logic                      dneg_dl [3];
  logic        [DirQW-1:0]   dir_q [3], dir_d [3];
  logic                      par_dl;

  ppi_sqrt #(
    .IN_W (SqInW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    ({s4_s_q, {LenShift{1'b0}}}),
    .root_o (len)
  );

  always_comb begin
    logic [CMagW-1:0] dm;
    for (int i = 0; i < 3; i++) begin
      dm = c_dl[i][CrossW-1] ? CMagW'(-c_dl[i]) : CMagW'(c_dl[i]);
      dn_num_d[i] = DirNumW'({dm, {DirShift{1'b0}}}) + DirNumW'(len >> 1);
      dn_neg_d[i] = c_dl[i][CrossW-1];
      if (dneg_dl[i]) begin
        dir_d[i] = (dovf[i] || dquo[i] > DirNegLim) ? DirNegLim : DirQW'(-dquo[i]);
      end else begin
        dir_d[i] = (dovf[i] || dquo[i] > DirPosLim) ? DirPosLim : dquo[i];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ppi_div #(
      .NUM_W (PNumW),
      .DEN_W (SumW),
      .Q_W   (PQW)
    ) u_pdiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s7_num_q[i]),
      .den_i (s7_s_q),
      .quo_o (pquo[i]),
      .ovf_o (povf[i])
    );

    ppi_delay #(.W(1), .DEPTH(PtDivLat)) u_pneg (
      .clk_i (clk_i), .en_i (en), .d_i (s7_neg_q[i]), .q_o (pneg_dl[i])
    );

    ppi_delay #(.W(CoordW), .DEPTH(PadDepth)) u_ppad (
      .clk_i (clk_i), .en_i (en), .d_i (pt_q[i]), .q_o (pt_dl[i])
    );

    ppi_delay #(.W(CrossW), .DEPTH(SqrtLat)) u_cdl (
      .clk_i (clk_i), .en_i (en), .d_i (s4_c_q[i]), .q_o (c_dl[i])
    );

    ppi_div #(
      .NUM_W (DirNumW),
      .DEN_W (LenW),
      .Q_W   (DirQW)
    ) u_ddiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dn_num_q[i]),
      .den_i (dn_len_q),
      .quo_o (dquo[i]),
      .ovf_o (dovf[i])
    );

    ppi_delay #(.W(1), .DEPTH(DirDivLat)) u_dneg (
      .clk_i (clk_i), .en_i (en), .d_i (dn_neg_q[i]), .q_o (dneg_dl[i])
    );
  end

  ppi_delay #(.W(1), .DEPTH(DirLat)) u_par (
    .clk_i (clk_i), .en_i (en), .d_i (s4_par_q), .q_o (par_dl)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pa_q   <= s1_pa_d;
      s1_pb_q   <= s1_pb_d;
      s1_b_q    <= in_b;
      s1_k2_q   <= s1_k2_d;
      s2_c_q    <= s2_c_d;
      s2_b_q    <= s1_b_q;
      s2_k2_q   <= s1_k2_q;
      s3_sq_q   <= s3_sq_d;
      s3_ua_q   <= s3_ua_d;
      s3_ub_q   <= s3_ub_d;
      s3_va_q   <= s3_va_d;
      s3_vb_q   <= s3_vb_d;
      s3_tol2_q <= s3_tol2_d;
      s3_c_q    <= s2_c_q;
      s3_k2_q   <= s2_k2_q;
      s4_s_q    <= s4_s_d;
      s4_par_q  <= s4_par_d;
      s4_u_q    <= s4_u_d;
      s4_v_q    <= s4_v_d;
      s4_c_q    <= s3_c_q;
      s4_k2_q   <= s3_k2_q;
      s5_ku_q   <= s5_ku_d;
      s5_kv_q   <= s5_kv_d;
      s5_s_q    <= s4_s_q;
      s6_n_q    <= s6_n_d;
      s6_s_q    <= s5_s_q;
      s7_num_q  <= s7_num_d;
      s7_neg_q  <= s7_neg_d;
      s7_s_q    <= s6_s_q;
      pt_q      <= pt_d;
      dn_num_q  <= dn_num_d;
      dn_neg_q  <= dn_neg_d;
      dn_len_q  <= len;
      dir_q     <= dir_d;
    end
  end

  // output FIFO
  res_t push_res;
  res_t out_res;
  res_t fifo_q [2];

  always_comb begin
    push_res.intersects = !par_dl;
    push_res.point_x    = par_dl ? '0 : pt_dl[0];
    push_res.point_y    = par_dl ? '0 : pt_dl[1];
    push_res.point_z    = par_dl ? '0 : pt_dl[2];
    push_res.dir_x      = par_dl ? '0 : dir_q[0];
    push_res.dir_y      = par_dl ? '0 : dir_q[1];
    push_res.dir_z      = par_dl ? '0 : dir_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= push_res;
    end
  end

  assign out_res      = fifo_q[rptr_q];
  assign intersects_o = out_res.intersects;
  assign point_x_o    = out_res.point_x;
  assign point_y_o    = out_res.point_y;
  assign point_z_o    = out_res.point_z;
  assign dir_x_o      = out_res.dir_x;
  assign dir_y_o      = out_res.dir_y;
  assign dir_z_o      = out_res.dir_z;

endmodule
